>>> sv/fpdm_pkg.sv
`default_nettype none
package fpdm_pkg;
    localparam int FW = 16;
    localparam int SLOTS = 64;
    localparam int LEVELS = 64;
    localparam int SW = 6;
    localparam int LVW = 6;
    localparam int DW = 30;
    localparam int LW = 21;
    localparam int BW = 7;
    localparam int MS_PER_S = 1000;

    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_FADE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_READ = 2'd3;

    typedef logic [BW-1:0] t_btab [LEVELS];

    typedef struct packed {
        logic          start;
        logic [3:0]    diode;
        logic [BW-1:0] count;
    } t_col_req;

    typedef struct packed {
        logic          start;
        logic [SW-1:0] slot;
    } t_rd_req;

    typedef struct packed {
        logic          busy;
        logic [FW-1:0] rdata;
    } t_frame_sts;

    function automatic t_btab f_btab();
        t_btab t;
        int    cube;
        int    b;
        int    e;
        for (int n = 0; n < LEVELS; n++) begin
            cube = n * n * n;
            b = 0;
            for (int k = 1; k <= LEVELS; k++) begin
                e = 8 * k - 4;
                if (e * e <= cube) begin
                    b = k;
                end
            end
            t[n] = BW'(b);
        end
        return t;
    endfunction

    localparam t_btab BTAB = f_btab();

    function automatic logic [LVW-1:0] f_clamp(input logic [7:0] v);
        return (v > 8'(LEVELS - 1)) ? LVW'(LEVELS - 1) : v[LVW-1:0];
    endfunction
endpackage
`default_nettype wire

>>> sv/fpdm_if.sv
`default_nettype none
interface fpdm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] led_sel;
    logic [7:0] level;
    logic [15:0] duration_ms;
    logic [5:0] slot;
    modport source (output valid, cmd, led_sel, level, duration_ms, slot, input ready);
    modport sink (input valid, cmd, led_sel, level, duration_ms, slot, output ready);
endinterface

interface fpdm_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [15:0] frame_word;
    modport source (output valid, status, frame_word, input ready);
    modport sink (input valid, status, frame_word, output ready);
endinterface
`default_nettype wire

>>> sv/fpdm_div.sv
`default_nettype none
module fpdm_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [fpdm_pkg::DW-1:0] i_dividend,
    input  wire logic [fpdm_pkg::LW-1:0] i_divisor,
    output logic                         o_done,
    output logic [fpdm_pkg::DW-1:0]      o_quotient
);
    localparam int DW = fpdm_pkg::DW;
    localparam int LW = fpdm_pkg::LW;
    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [LW:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [LW-1:0] r_div;
    logic [LW:0]   w_sh;
    logic          w_ge;

    assign w_sh = {r_rem[LW-1:0], r_quo[DW-1]};
    assign w_ge = w_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_div}) : w_sh;
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

>>> sv/fpdm_frame.sv
`default_nettype none
module fpdm_frame (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire fpdm_pkg::t_col_req   i_col,
    input  wire fpdm_pkg::t_rd_req    i_rd,
    output fpdm_pkg::t_frame_sts      o_sts
);
    localparam int FW = fpdm_pkg::FW;
    localparam int SW = fpdm_pkg::SW;
    localparam int BW = fpdm_pkg::BW;
    localparam int AW = 13;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RD   = 2'd1;
    localparam logic [1:0] F_WR   = 2'd2;

    logic [FW-1:0] r_mem [fpdm_pkg::SLOTS];
    logic [fpdm_pkg::SLOTS-1:0] r_vld;
    logic [1:0]    r_state;
    logic [SW-1:0] r_s;
    logic [AW-1:0] r_acc;
    logic [BW-1:0] r_b;
    logic [3:0]    r_d;
    logic [FW-1:0] r_rdata;
    logic [SW-1:0] w_raddr;
    logic          w_ren;
    logic [AW-1:0] w_hi;
    logic [AW-1:0] w_lo;
    logic          w_lit;
    logic [FW-1:0] w_bit;
    logic [FW-1:0] w_wdata;

    assign w_hi    = (r_acc + AW'(r_b) + AW'(63)) >> 6;
    assign w_lo    = (r_acc + AW'(63)) >> 6;
    assign w_lit   = w_hi != w_lo;
    assign w_bit   = FW'(1) << r_d;
    assign w_wdata = w_lit ? (r_rdata | w_bit) : (r_rdata & ~w_bit);
    assign w_raddr = (r_state == F_RD) ? r_s : i_rd.slot;
    assign w_ren   = (r_state == F_RD) || i_rd.start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_vld   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_col.start) begin
                        r_state <= F_RD;
                    end
                end
                F_RD: begin
                    r_state <= F_WR;
                end
                F_WR: begin
                    r_vld[r_s] <= 1'b1;
                    r_state    <= (r_s == SW'(fpdm_pkg::SLOTS - 1)) ? F_IDLE : F_RD;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_col.start) begin
            r_s   <= '0;
            r_acc <= '0;
            r_b   <= i_col.count;
            r_d   <= i_col.diode;
        end else if (r_state == F_WR) begin
            r_s   <= r_s + 1'b1;
            r_acc <= r_acc + AW'(r_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_WR) begin
            r_mem[r_s] <= w_wdata;
        end
        if (w_ren) begin
            r_rdata <= r_vld[w_raddr] ? r_mem[w_raddr] : '0;
        end
    end

    assign o_sts.busy  = r_state != F_IDLE;
    assign o_sts.rdata = r_rdata;
endmodule
`default_nettype wire

>>> sv/multi_channel_fade_pdm_controller.sv
// From request accept to response valid, a valid set passes S_APPLY and S_DONE; a read S_READ, S_RWAIT, S_DONE.
// A fade start goes through the shared divider (ms * rate / 1000), then S_APPLY if zero length.
// Tick: each idle diode is skipped in S_TCHK; each fading diode goes through the same divider.
// A level change adds the frame column rewrite, a read and a write of every slot.
// One request at a time; the next is taken the cycle after the response is accepted.
// Reset (synchronous, active low) clears all diode state, frame words and rate = 1000.
`default_nettype none
module multi_channel_fade_pdm_controller #(
    parameter int NUM_DIODES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [13:0] i_cfg_wdata,
    fpdm_req_if.sink         i_req,
    fpdm_rsp_if.source       o_rsp
);
    localparam int IW  = (NUM_DIODES > 1) ? $clog2(NUM_DIODES) : 1;
    localparam int DW  = fpdm_pkg::DW;
    localparam int LW  = fpdm_pkg::LW;
    localparam int LVW = fpdm_pkg::LVW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FMUL   = 4'd1;
    localparam logic [3:0] S_TCHK   = 4'd2;
    localparam logic [3:0] S_TMUL   = 4'd3;
    localparam logic [3:0] S_DSTART = 4'd4;
    localparam logic [3:0] S_DWAIT  = 4'd5;
    localparam logic [3:0] S_APPLY  = 4'd6;
    localparam logic [3:0] S_CWAIT  = 4'd7;
    localparam logic [3:0] S_READ   = 4'd8;
    localparam logic [3:0] S_RWAIT  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [LVW-1:0] r_cur  [NUM_DIODES];
    logic [LVW-1:0] r_src  [NUM_DIODES];
    logic [7:0]     r_tgt  [NUM_DIODES];
    logic [LW-1:0]  r_len  [NUM_DIODES];
    logic [LW-1:0]  r_tick [NUM_DIODES];

    logic [3:0]     r_state;
    logic [13:0]    r_tps;
    logic [1:0]     r_cmd;
    logic [7:0]     r_level;
    logic [15:0]    r_dur;
    logic [5:0]     r_slot;
    logic [IW:0]    r_idx;
    logic [LVW-1:0] r_lvl;
    logic [DW-1:0]  r_prod;
    logic           r_neg;
    logic           r_status;
    logic           r_ovalid;
    logic [15:0]    r_word;

    logic [IW-1:0]  w_i;
    logic           w_dvalid;
    logic [7:0]     w_mag;
    logic           w_neg;
    logic [LW-1:0]  w_tp1;
    logic [8:0]     w_v;
    logic           w_col_ok;
    logic           w_div_done;
    logic [DW-1:0]  w_quo;
    logic [LW-1:0]  w_divisor;
    fpdm_pkg::t_col_req   w_col;
    fpdm_pkg::t_rd_req    w_rd;
    fpdm_pkg::t_frame_sts w_fsts;

    assign w_i       = r_idx[IW-1:0];
    assign w_dvalid  = i_req.led_sel < 8'(NUM_DIODES);
    assign w_neg     = r_tgt[w_i] < 8'(r_src[w_i]);
    assign w_mag     = w_neg ? (8'(r_src[w_i]) - r_tgt[w_i]) : (r_tgt[w_i] - 8'(r_src[w_i]));
    assign w_tp1     = r_tick[w_i] + 1'b1;
    assign w_v       = r_neg ? (9'(r_src[w_i]) - w_quo[8:0]) : (9'(r_src[w_i]) + w_quo[8:0]);
    assign w_col_ok  = 6'(w_i) < 6'(fpdm_pkg::FW);
    assign w_divisor = (r_cmd == fpdm_pkg::CMD_FADE) ? LW'(fpdm_pkg::MS_PER_S) : r_len[w_i];

    assign w_col.start = (r_state == S_APPLY) && (r_cur[w_i] != r_lvl) && w_col_ok;
    assign w_col.diode = 4'(w_i);
    assign w_col.count = fpdm_pkg::BTAB[r_lvl];
    assign w_rd.start  = r_state == S_READ;
    assign w_rd.slot   = r_slot;

    fpdm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_prod),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    fpdm_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_col   (w_col),
        .i_rd    (w_rd),
        .o_sts   (w_fsts)
    );

    assign i_req.ready      = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_status;
    assign o_rsp.frame_word = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tps    <= 14'd1000;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            for (int k = 0; k < NUM_DIODES; k++) begin
                r_cur[k]  <= '0;
                r_src[k]  <= '0;
                r_tgt[k]  <= '0;
                r_len[k]  <= '0;
                r_tick[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_cmd    <= i_req.cmd;
                        r_level  <= i_req.level;
                        r_dur    <= i_req.duration_ms;
                        r_slot   <= i_req.slot;
                        r_lvl    <= fpdm_pkg::f_clamp(i_req.level);
                        r_word   <= '0;
                        unique case (i_req.cmd)
                            fpdm_pkg::CMD_SET: begin
                                r_idx    <= (IW + 1)'(i_req.led_sel[IW-1:0]);
                                r_status <= !w_dvalid;
                                r_state  <= w_dvalid ? S_APPLY : S_DONE;
                            end
                            fpdm_pkg::CMD_FADE: begin
                                r_idx    <= (IW + 1)'(i_req.led_sel[IW-1:0]);
                                r_status <= !w_dvalid;
                                r_state  <= w_dvalid ? S_FMUL : S_DONE;
                            end
                            fpdm_pkg::CMD_TICK: begin
                                r_idx    <= '0;
                                r_status <= 1'b0;
                                r_state  <= S_TCHK;
                            end
                            fpdm_pkg::CMD_READ: begin
                                r_status <= 1'b0;
                                r_state  <= S_READ;
                            end
                            default: begin
                                r_status <= 1'b0;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_FMUL: begin
                    r_prod  <= DW'(r_dur) * DW'(r_tps);
                    r_state <= S_DSTART;
                end
                S_TCHK: begin
                    if (r_idx == (IW + 1)'(NUM_DIODES)) begin
                        r_state <= S_DONE;
                    end else if (r_tick[w_i] == r_len[w_i] || r_len[w_i] == '0) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    r_prod  <= DW'(w_mag) * DW'(w_tp1);
                    r_neg   <= w_neg;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        if (r_cmd == fpdm_pkg::CMD_FADE) begin
                            r_src[w_i]  <= r_cur[w_i];
                            r_tgt[w_i]  <= r_level;
                            r_len[w_i]  <= w_quo[LW-1:0];
                            r_tick[w_i] <= '0;
                            r_state     <= (w_quo == '0) ? S_APPLY : S_DONE;
                        end else begin
                            r_lvl       <= fpdm_pkg::f_clamp(w_v[7:0]);
                            r_tick[w_i] <= w_tp1;
                            r_state     <= S_APPLY;
                        end
                    end
                end
                S_APPLY: begin
                    r_cur[w_i] <= r_lvl;
                    if (w_col.start) begin
                        r_state <= S_CWAIT;
                    end else if (r_cmd == fpdm_pkg::CMD_TICK) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_TCHK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CWAIT: begin
                    if (!w_fsts.busy) begin
                        if (r_cmd == fpdm_pkg::CMD_TICK) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_TCHK;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_word  <= w_fsts.rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_ready_frame_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !w_fsts.busy)
        else $error("request taken while frame column busy");
    a_done_gives_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_ovalid)
        else $error("finished request gave no response");
    a_err_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_status && (r_word != '0)))
        else $error("error response carries a frame word");
    a_div_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside its wait state");
`endif
endmodule
`default_nettype wire

>>> test/multi_channel_fade_pdm_controller_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_fade_pdm_controller_tb;

    localparam int NDIODE = 16;

    class fade_frame_board;
        int unsigned   tick_rate;
        bit [5:0]      cur_lvl [NDIODE];
        bit [7:0]      src_lvl [NDIODE];
        bit [7:0]      tgt_lvl [NDIODE];
        bit [31:0]     fade_len [NDIODE];
        bit [31:0]     fade_pos [NDIODE];
        bit [15:0]     frames [fpdm_pkg::SLOTS];
        bit [16:0]     pending [$];
        int            errors;

        function void clear();
            tick_rate = 1000;
            foreach (cur_lvl[i]) begin
                cur_lvl[i] = 0;
                src_lvl[i] = 0;
                tgt_lvl[i] = 0;
                fade_len[i] = 0;
                fade_pos[i] = 0;
            end
            foreach (frames[s]) begin
                frames[s] = 0;
            end
            pending.delete();
            errors = 0;
        endfunction

        function bit [63:0] density(int unsigned n);
            longint unsigned cube;
            longint unsigned e;
            int unsigned     b;
            bit [63:0]       pat;
            cube = longint'(n) * n * n;
            b = 0;
            pat = 0;
            for (int k = 1; k <= fpdm_pkg::LEVELS; k++) begin
                e = 8 * k - 4;
                if (e * e <= cube) begin
                    b = k;
                end
            end
            for (int i = 0; i < b; i++) begin
                pat[(fpdm_pkg::LEVELS * i) / b] = 1'b1;
            end
            return pat;
        endfunction

        function void drive_level(int d, bit [7:0] lvl);
            bit [5:0]  c;
            bit [63:0] pat;
            c = (lvl > 63) ? 6'd63 : lvl[5:0];
            if (cur_lvl[d] == c) begin
                return;
            end
            cur_lvl[d] = c;
            pat = density(c);
            for (int s = 0; s < fpdm_pkg::SLOTS; s++) begin
                frames[s][d] = pat[s];
            end
        endfunction

        function void note_request(bit [1:0] cmd, bit [7:0] d, bit [7:0] lvl,
                                   bit [15:0] ms, bit [5:0] slot);
            bit        sts;
            bit [15:0] word;
            longint    rng;
            longint    v;
            sts = 0;
            word = 0;
            case (cmd)
                fpdm_pkg::CMD_SET: begin
                    if (d < NDIODE) drive_level(d, lvl);
                    else sts = 1;
                end
                fpdm_pkg::CMD_FADE: begin
                    if (d < NDIODE) begin
                        src_lvl[d] = cur_lvl[d];
                        tgt_lvl[d] = lvl;
                        fade_len[d] = (longint'(ms) * tick_rate) / fpdm_pkg::MS_PER_S;
                        fade_pos[d] = 0;
                        if (fade_len[d] == 0) drive_level(d, lvl);
                    end else begin
                        sts = 1;
                    end
                end
                fpdm_pkg::CMD_TICK: begin
                    for (int i = 0; i < NDIODE; i++) begin
                        if (fade_pos[i] == fade_len[i] || fade_len[i] == 0) continue;
                        rng = longint'(tgt_lvl[i]) - longint'(src_lvl[i]);
                        v = longint'(src_lvl[i])
                            + (rng * (longint'(fade_pos[i]) + 1)) / longint'(fade_len[i]);
                        drive_level(i, v[7:0]);
                        fade_pos[i]++;
                    end
                end
                default: word = frames[slot];
            endcase
            pending.push_back({sts, word});
        endfunction

        function void check_response(bit sts, bit [15:0] word);
            bit [16:0] exp_rsp;
            if (pending.size() == 0) begin
                $error("unexpected response status=%0d frame_word=%h", sts, word);
                errors++;
                return;
            end
            exp_rsp = pending.pop_front();
            if (exp_rsp[16] !== sts) begin
                $error("status expected %0d actual %0d", exp_rsp[16], sts);
                errors++;
            end
            if (exp_rsp[15:0] !== word) begin
                $error("frame_word expected %h actual %h", exp_rsp[15:0], word);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [13:0] cfg_wdata;
    bit          calm;
    bit          timed_out;
    fade_frame_board board;

    fpdm_req_if req_if ();
    fpdm_rsp_if rsp_if ();

    multi_channel_fade_pdm_controller #(.NUM_DIODES(NDIODE)) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial begin
        board = new();
        board.clear();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        calm = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = fpdm_pkg::CMD_SET;
        req_if.led_sel = '0;
        req_if.level = '0;
        req_if.duration_ms = '0;
        req_if.slot = '0;
        rsp_if.ready = 1'b0;
    end

    // receiver checks each accepted response; its ready stalls in bursts below
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                board.check_response(rsp_if.status, rsp_if.frame_word);
            end
        end
    end

    initial begin
        int n;
        @(posedge clk);
        while (1) begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 18);
                rsp_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_request(bit [1:0] cmd, bit [7:0] d, bit [7:0] lvl,
                                bit [15:0] ms, bit [5:0] slot);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd <= cmd;
        req_if.led_sel <= d;
        req_if.level <= lvl;
        req_if.duration_ms <= ms;
        req_if.slot <= slot;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        board.note_request(cmd, d, lvl, ms, slot);
    endtask

    task automatic drain();
        req_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_rate(bit [13:0] rate);
        cfg_we <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        board.tick_rate = rate;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_all();
        for (int s = 0; s < fpdm_pkg::SLOTS; s += 5) begin
            send_request(fpdm_pkg::CMD_READ, 0, 0, 0, s[5:0]);
        end
    endtask

    task automatic random_request();
        int        pick;
        bit [7:0]  d;
        bit [15:0] ms;
        pick = $urandom_range(0, 99);
        d = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, NDIODE - 1));
        ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if (pick < 20) begin
            send_request(fpdm_pkg::CMD_SET, d, 8'($urandom), 16'($urandom), 6'($urandom));
        end else if (pick < 35) begin
            send_request(fpdm_pkg::CMD_FADE, d, 8'($urandom), ms, 6'($urandom));
        end else if (pick < 65) begin
            send_request(fpdm_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom),
                         6'($urandom));
        end else begin
            send_request(fpdm_pkg::CMD_READ, 8'($urandom), 8'($urandom), 16'($urandom),
                         6'($urandom));
        end
    endtask

    initial begin
        bit [13:0] rates [5];
        rates = '{14'd1, 14'd10000, 14'd16383, 14'd0, 14'd250};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(fpdm_pkg::CMD_SET, 0, 8'd63, 0, 0);
        send_request(fpdm_pkg::CMD_SET, 0, 8'd63, 0, 0);
        send_request(fpdm_pkg::CMD_SET, 15, 8'd255, 0, 0);
        send_request(fpdm_pkg::CMD_SET, 1, 8'd1, 0, 0);
        send_request(fpdm_pkg::CMD_SET, 16, 8'd5, 0, 0);
        send_request(fpdm_pkg::CMD_SET, 255, 8'd5, 0, 0);
        send_request(fpdm_pkg::CMD_FADE, 200, 8'd5, 16'd10, 0);
        send_request(fpdm_pkg::CMD_FADE, 2, 8'd40, 16'd0, 0);
        send_request(fpdm_pkg::CMD_FADE, 3, 8'd200, 16'd5, 0);
        send_request(fpdm_pkg::CMD_FADE, 0, 8'd0, 16'd4, 0);
        send_request(fpdm_pkg::CMD_FADE, 4, 8'd255, 16'd65535, 0);
        repeat (7) send_request(fpdm_pkg::CMD_TICK, 8'hff, 8'hff, 16'hffff, 6'h3f);
        send_request(fpdm_pkg::CMD_READ, 8'hff, 8'hff, 16'hffff, 6'd0);
        send_request(fpdm_pkg::CMD_READ, 0, 0, 0, 6'd63);
        send_request(fpdm_pkg::CMD_READ, 0, 0, 0, 6'd32);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_rate(rates[ph]);
            for (int k = 0; k < 240; k++) random_request();
            read_all();
            drain();
        end
        write_rate(14'd1000);
        calm = 1'b1;
        for (int k = 0; k < 200; k++) random_request();
        read_all();
        drain();

        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        timed_out = 1'b0;
        #250ms;
        timed_out = 1'b1;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
